### src/apcp_pkg.sv
// Shared types, constants and trig tables for the antenna pair cosine product map.
// Depends on nothing; every module of the block imports it.
package apcp_pkg;

  // Angles are in quarter degrees.
  localparam int TURN_Q = 1440;
  localparam int HALF_QUAD_Q = 180;
  localparam int QUAD_Q = 360;
  localparam int TILT_Q = 40;
  localparam int MAX_SEP = 2;

  localparam int COARSE_NPHI = 180;
  localparam int COARSE_PHI_MIN_Q = 0;
  localparam int COARSE_PHI_W_Q = 8;
  localparam int COARSE_NTH = 100;
  localparam int COARSE_TH_MIN_Q = -240;
  localparam int COARSE_TH_W_Q = 4;
  localparam int FINE_NPHI = 760;
  localparam int FINE_PHI_MIN_Q = -40;
  localparam int FINE_PHI_W_Q = 2;
  localparam int FINE_NTH = 240;
  localparam int FINE_TH_MIN_Q = -280;
  localparam int FINE_TH_W_Q = 2;

  localparam int DEF_PHI_SECTORS = 16;
  localparam int DEF_ANTENNA_COUNT = 48;
  localparam int DEF_FRACTION_BITS = 16;

  // Biased angle width and the reciprocal used to reduce it modulo a turn.
  localparam int ANGLE_W = 14;
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_TURN = (1 << RECIP_SHIFT) / TURN_Q;

  localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
  localparam longint unsigned QSTEP_Q60 = PI_Q60 / 720;

  typedef enum logic [2:0] {
    REG_FINE_GRID      = 3'd0,
    REG_FIRST_ANTENNA  = 3'd1,
    REG_SECOND_ANTENNA = 3'd2,
    REG_FIRST_AZIMUTH  = 3'd3,
    REG_SECOND_AZIMUTH = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic mod_en;
    logic fold_en;
    logic lut_en;
  } sc_en_t;

  typedef logic [30:0] trig_tab_t [0:HALF_QUAD_Q];

  // Q30 Taylor kernel over 0..45 degrees, evaluated at elaboration.
  function automatic trig_tab_t build_trig_tab(input bit want_cos);
    trig_tab_t tab;
    longint unsigned one;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    one = 64'd1 << 30;
    for (int r = 0; r <= HALF_QUAD_Q; r++) begin
      x = (64'(r) * QSTEP_Q60) >> 30;
      x2 = (x * x) >> 30;
      t = one - x2 / 72;
      t = one - ((x2 * t) >> 30) / 42;
      t = one - ((x2 * t) >> 30) / 20;
      t = one - ((x2 * t) >> 30) / 6;
      s = (x * t) >> 30;
      t = one - x2 / 90;
      t = one - ((x2 * t) >> 30) / 56;
      t = one - ((x2 * t) >> 30) / 30;
      t = one - ((x2 * t) >> 30) / 12;
      t = one - ((x2 * t) >> 30) / 2;
      tab[r] = want_cos ? t[30:0] : s[30:0];
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_trig_tab(1'b0);
  localparam trig_tab_t COS_TAB = build_trig_tab(1'b1);

  // Q30 product rescale, truncating toward zero.
  function automatic logic signed [31:0] q30_trunc(input logic signed [63:0] p);
    logic signed [63:0] adj;
    adj = p + (p[63] ? 64'sd1073741823 : 64'sd0);
    return 32'(adj >>> 30);
  endfunction

endpackage

### src/antenna_pair_cosine_product_map.sv
// Top level of the antenna pair cosine product map: config registers and the bin pipeline.
// Depends on apcp_pkg and apcp_sincos.

// Streams sky-map bins at one bin per clock while the out channel is ready. An input
// transfer reaches the out channel through ten register stages, which are, in order:
// bin angles, three stages of angle reduction and Q30 table lookup, then the spherical
// cosine (tilt products, their rescale, the azimuth products, the sum and clip), the
// cosine product and the saturating output register. Stalls on the out channel back up
// through the stages, and empty stages are filled, so in_ready stays high while any
// stage is free. Configuration must be written only while no bin is in flight.
module antenna_pair_cosine_product_map import apcp_pkg::*; #(
  parameter int PHI_SECTORS   = DEF_PHI_SECTORS,
  parameter int ANTENNA_COUNT = DEF_ANTENNA_COUNT,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  in_azimuth_bin,
  input  logic [7:0]  in_elevation_bin,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_cosine_product,
  output logic        out_pair_enabled,
  output logic        out_bin_on_grid
);

  localparam int NSTAGE = 10;
  localparam int PROD_SHIFT = 60 - FRACTION_BITS;
  localparam int PHI_BIAS = 2 * TURN_Q;
  localparam int TH_BIAS = TURN_Q;
  localparam int COARSE_PHI_OFS = PHI_BIAS + COARSE_PHI_MIN_Q - COARSE_PHI_W_Q / 2;
  localparam int FINE_PHI_OFS = PHI_BIAS + FINE_PHI_MIN_Q - FINE_PHI_W_Q / 2;
  localparam int COARSE_TH_OFS = TH_BIAS + COARSE_TH_MIN_Q - COARSE_TH_W_Q / 2;
  localparam int FINE_TH_OFS = TH_BIAS + FINE_TH_MIN_Q - FINE_TH_W_Q / 2;

  localparam logic signed [31:0] SIN_TILT = $signed({1'b0, SIN_TAB[TILT_Q]});
  localparam logic signed [31:0] COS_TILT = $signed({1'b0, COS_TAB[TILT_Q]});

  // config registers
  logic        fine_grid_r;
  logic [5:0]  first_antenna_r, second_antenna_r;
  logic [10:0] first_azimuth_r, second_azimuth_r;

  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE-1:0] en;
  logic [1:0]        flag_r [0:NSTAGE-1];

  // stage 1
  logic [ANGLE_W-1:0] th_r, dphi1_r, dphi2_r;
  logic [15:0] phi_off, th_off;
  logic [15:0] dphi1_full, dphi2_full;
  logic        on_grid, pair_ok;
  logic [5:0]  sep_abs;
  logic [12:0] sep_rem;
  logic [12:0] sep_fold;

  // sincos outputs
  logic signed [31:0] s_th, c_th, c_d1, c_d2;
  sc_en_t sc_en;

  // stages 5..10
  logic signed [63:0] pct_r, pst_r;
  logic signed [31:0] cd1_5_r, cd2_5_r;
  logic signed [31:0] a_r, b_r, cd1_6_r, cd2_6_r;
  logic signed [63:0] q1_r, q2_r;
  logic signed [31:0] b_7_r;
  logic signed [32:0] v1, v2;
  logic [30:0] c1_r, c2_r;
  logic [61:0] prod_r;
  logic [61:0] prod_shifted;
  logic [15:0] cprod_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fine_grid_r <= 1'b0;
      first_antenna_r <= '0;
      second_antenna_r <= '0;
      first_azimuth_r <= '0;
      second_azimuth_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FINE_GRID:      fine_grid_r <= cfg_data[0];
        REG_FIRST_ANTENNA:  first_antenna_r <= cfg_data[5:0];
        REG_SECOND_ANTENNA: second_antenna_r <= cfg_data[5:0];
        REG_FIRST_AZIMUTH:  first_azimuth_r <= cfg_data;
        REG_SECOND_AZIMUTH: second_azimuth_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage moves when it is empty or the next one moves
  always_comb begin
    en[NSTAGE-1] = !v_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  // bin centers, biased to stay positive before modulo reduction
  always_comb begin
    if (fine_grid_r) begin
      phi_off = 16'({in_azimuth_bin, 1'b0}) + 16'(FINE_PHI_OFS);
      th_off = 16'({in_elevation_bin, 1'b0}) + 16'(FINE_TH_OFS);
      on_grid = in_azimuth_bin >= 10'd1 && in_azimuth_bin <= 10'(FINE_NPHI) &&
                in_elevation_bin >= 8'd1 && in_elevation_bin <= 8'(FINE_NTH);
    end else begin
      phi_off = 16'({in_azimuth_bin, 3'b000}) + 16'(COARSE_PHI_OFS);
      th_off = 16'({in_elevation_bin, 2'b00}) + 16'(COARSE_TH_OFS);
      on_grid = in_azimuth_bin >= 10'd1 && in_azimuth_bin <= 10'(COARSE_NPHI) &&
                in_elevation_bin >= 8'd1 && in_elevation_bin <= 8'(COARSE_NTH);
    end
    dphi1_full = phi_off - 16'(first_azimuth_r);
    dphi2_full = phi_off - 16'(second_azimuth_r);
  end

  // sector separation: restoring reduction modulo PHI_SECTORS, folded, then the pair check
  always_comb begin
    sep_abs = (first_antenna_r >= second_antenna_r) ? first_antenna_r - second_antenna_r
                                                    : second_antenna_r - first_antenna_r;
    sep_rem = 13'(sep_abs);
    for (int i = 5; i >= 0; i--) begin
      if (sep_rem >= (13'(PHI_SECTORS) << i)) begin
        sep_rem = sep_rem - (13'(PHI_SECTORS) << i);
      end
    end
    sep_fold = sep_rem;
    if (13'(PHI_SECTORS) - sep_rem < sep_rem) begin
      sep_fold = 13'(PHI_SECTORS) - sep_rem;
    end
    pair_ok = sep_fold <= 13'(MAX_SEP) &&
              {1'b0, first_antenna_r} < 7'(ANTENNA_COUNT) &&
              {1'b0, second_antenna_r} < 7'(ANTENNA_COUNT);
  end

  assign sc_en = '{mod_en: en[1], fold_en: en[2], lut_en: en[3]};

  apcp_sincos u_sc_th (
    .clk   (clk),
    .en    (sc_en),
    .angle (th_r),
    .sin_o (s_th),
    .cos_o (c_th)
  );

  apcp_sincos u_sc_d1 (
    .clk   (clk),
    .en    (sc_en),
    .angle (dphi1_r),
    .sin_o (),
    .cos_o (c_d1)
  );

  apcp_sincos u_sc_d2 (
    .clk   (clk),
    .en    (sc_en),
    .angle (dphi2_r),
    .sin_o (),
    .cos_o (c_d2)
  );

  always_comb begin
    v1 = 33'(q30_trunc(q1_r)) + 33'(b_7_r);
    v2 = 33'(q30_trunc(q2_r)) + 33'(b_7_r);
    prod_shifted = prod_r >> PROD_SHIFT;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en[0]) begin
      th_r <= th_off[ANGLE_W-1:0];
      dphi1_r <= dphi1_full[ANGLE_W-1:0];
      dphi2_r <= dphi2_full[ANGLE_W-1:0];
      flag_r[0] <= {pair_ok, on_grid};
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (en[k]) begin
        flag_r[k] <= flag_r[k-1];
      end
    end
    if (en[4]) begin
      pct_r <= c_th * COS_TILT;
      pst_r <= (-s_th) * SIN_TILT;
      cd1_5_r <= c_d1;
      cd2_5_r <= c_d2;
    end
    if (en[5]) begin
      a_r <= q30_trunc(pct_r);
      b_r <= q30_trunc(pst_r);
      cd1_6_r <= cd1_5_r;
      cd2_6_r <= cd2_5_r;
    end
    if (en[6]) begin
      q1_r <= a_r * cd1_6_r;
      q2_r <= a_r * cd2_6_r;
      b_7_r <= b_r;
    end
    if (en[7]) begin
      c1_r <= (v1 > 33'sd0) ? v1[30:0] : '0;
      c2_r <= (v2 > 33'sd0) ? v2[30:0] : '0;
    end
    if (en[8]) begin
      prod_r <= 62'(c1_r) * 62'(c2_r);
    end
    if (en[9]) begin
      cprod_r <= (|prod_shifted[61:16]) ? 16'hFFFF : prod_shifted[15:0];
    end
  end

  assign out_valid = v_r[NSTAGE-1];
  assign out_cosine_product = cprod_r;
  assign out_pair_enabled = flag_r[NSTAGE-1][1];
  assign out_bin_on_grid = flag_r[NSTAGE-1][0];

  // an empty output stage lets the whole pipe move
  assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> in_ready)
    else $error("in_ready low with an empty output stage");

  // a held stage keeps its item
  assert property (@(posedge clk) disable iff (!rst_n) (v_r[4] && !en[5]) |=> v_r[4])
    else $error("item dropped from a stalled stage");

  // input ready follows the pipe's first stage
  assert property (@(posedge clk) disable iff (!rst_n) (v_r[0] && !en[1]) |-> !in_ready)
    else $error("transfer accepted into a blocked first stage");

endmodule

### src/apcp_sincos.sv
// Three-stage sine/cosine of a biased quarter-degree angle: reduce, fold, table lookup.
// Depends on apcp_pkg (tables, enables struct, angle constants).
module apcp_sincos import apcp_pkg::*; (
  input  logic                      clk,
  input  sc_en_t                    en,
  input  logic [ANGLE_W-1:0]        angle,
  output logic signed [31:0]        sin_o,
  output logic signed [31:0]        cos_o
);

  logic [10:0] mod_r, mod_nxt;
  logic [1:0]  quad_r, quad_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic        swap_r, swap_nxt;
  logic signed [31:0] sin_r, sin_nxt, cos_r, cos_nxt;

  logic [25:0] recip_prod;
  logic [3:0]  q_est;
  logic [11:0] rem;
  logic [8:0]  r_in_quad;
  logic [30:0] s0, c0;
  logic signed [31:0] s0s, c0s;

  // angle modulo a turn: underestimated quotient, one correction
  always_comb begin
    recip_prod = 26'(angle) * 26'(RECIP_TURN);
    q_est = recip_prod[RECIP_SHIFT +: 4];
    rem = 12'(angle - 14'(q_est * 14'(TURN_Q)));
    if (rem >= 12'(TURN_Q)) begin
      mod_nxt = 11'(rem - 12'(TURN_Q));
    end else begin
      mod_nxt = rem[10:0];
    end
  end

  always_comb begin
    if (mod_r >= 11'(3 * QUAD_Q)) begin
      quad_nxt = 2'd3;
    end else if (mod_r >= 11'(2 * QUAD_Q)) begin
      quad_nxt = 2'd2;
    end else if (mod_r >= 11'(QUAD_Q)) begin
      quad_nxt = 2'd1;
    end else begin
      quad_nxt = 2'd0;
    end
    r_in_quad = 9'(mod_r - 11'(quad_nxt) * 11'(QUAD_Q));
    if (r_in_quad <= 9'(HALF_QUAD_Q)) begin
      idx_nxt = r_in_quad[7:0];
      swap_nxt = 1'b0;
    end else begin
      idx_nxt = 8'(9'(QUAD_Q) - r_in_quad);
      swap_nxt = 1'b1;
    end
  end

  always_comb begin
    s0 = swap_r ? COS_TAB[idx_r] : SIN_TAB[idx_r];
    c0 = swap_r ? SIN_TAB[idx_r] : COS_TAB[idx_r];
    s0s = $signed({1'b0, s0});
    c0s = $signed({1'b0, c0});
    case (quad_r)
      2'd0: begin
        sin_nxt = s0s;
        cos_nxt = c0s;
      end
      2'd1: begin
        sin_nxt = c0s;
        cos_nxt = -s0s;
      end
      2'd2: begin
        sin_nxt = -s0s;
        cos_nxt = -c0s;
      end
      default: begin
        sin_nxt = -c0s;
        cos_nxt = s0s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.mod_en) begin
      mod_r <= mod_nxt;
    end
    if (en.fold_en) begin
      quad_r <= quad_nxt;
      idx_r <= idx_nxt;
      swap_r <= swap_nxt;
    end
    if (en.lut_en) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule
